@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (!(expr))) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

@@ rtl/core/sha_pkg.sv @@
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  localparam logic [5:0] FillLast   = 6'(BlockBytes - 1);
  localparam logic [5:0] LengthPos  = 6'd56;
  localparam logic [5:0] RoundLast  = 6'(Rounds - 1);
  localparam logic [7:0] PadMark    = 8'h80;
  localparam logic [2:0] WordLast   = 3'd7;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha_state_e;

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } sha_src_e;

  typedef struct packed {
    logic     shift;
    sha_src_e src;
    logic     load;
    logic     round;
    logic     add;
    logic     out_adv;
    logic     clear;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       idx_last;
  } sha_status_t;

endpackage

@@ rtl/core/sha_if.sv @@
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/core/sha_dp.sv @@
module sha_dp
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha_cmd_t    cmd_i,
  input  logic [7:0]  data_byte_i,
  output sha_status_t status_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] hash_q [8];
  logic [31:0] hash_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] bits_q, bits_d;

  logic [7:0]  byte_in;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;
  logic [31:0] sm_s0, sm_s1, w_next;

  // byte into the block buffer
  always_comb begin
    case (cmd_i.src)
      SRC_MSG:  byte_in = data_byte_i;
      SRC_MARK: byte_in = PadMark;
      SRC_ZERO: byte_in = 8'h00;
      SRC_LEN:  byte_in = bits_q[{~fill_q[2:0], 3'b000} +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  // one compression round and one schedule word
  always_comb begin
    big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1     = v_q[7] + big_s1 + ch + RoundK[round_q] + win_q[0];
    big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2     = big_s0 + maj;
    sm_s0  = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    sm_s1  = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_next = sm_s1 + win_q[9] + sm_s0 + win_q[0];
  end

  always_comb begin
    hash_d  = hash_q;
    v_d     = v_q;
    win_d   = win_q;
    fill_d  = fill_q;
    round_d = round_q;
    idx_d   = idx_q;
    bits_d  = bits_q;

    if (cmd_i.shift) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[15] = {win_q[15][23:0], byte_in};
      fill_d    = fill_q + 6'd1;
      if (cmd_i.src == SRC_MSG) begin
        bits_d = bits_q + 64'd8;
      end
    end

    if (cmd_i.load) begin
      v_d     = hash_q;
      round_d = '0;
    end

    if (cmd_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = w_next;
      round_d   = round_q + 6'd1;
    end

    if (cmd_i.add) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + v_q[i];
      end
    end

    if (cmd_i.out_adv) begin
      idx_d = idx_q + 3'd1;
    end

    if (cmd_i.clear) begin
      hash_d = HashInit;
      bits_d = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= HashInit;
      fill_q  <= '0;
      round_q <= '0;
      idx_q   <= '0;
      bits_q  <= '0;
    end else begin
      hash_q  <= hash_d;
      fill_q  <= fill_d;
      round_q <= round_d;
      idx_q   <= idx_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    win_q <= win_d;
  end

  assign status_o.fill       = fill_q;
  assign status_o.round_last = (round_q == RoundLast);
  assign status_o.idx_last   = (idx_q == WordLast);

  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == WordLast);

endmodule

@@ rtl/core/sha_ctrl.sv @@
module sha_ctrl
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  input  logic        out_ready_i,
  input  sha_status_t status_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output sha_cmd_t    cmd_o
);

  sha_state_e state_q, state_d;
  logic       end_q, end_d;
  logic       mark_q, mark_d;
  logic       len_q, len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      end_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    end_d       = end_q;
    mark_d      = mark_q;
    len_d       = len_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.src   = SRC_MSG;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_present_i) begin
            cmd_o.shift = 1'b1;
            cmd_o.src   = SRC_MSG;
          end
          if (byte_present_i && status_i.fill == FillLast) begin
            end_d   = end_of_message_i;
            state_d = ST_LOAD;
          end else if (end_of_message_i) begin
            end_d   = 1'b1;
            state_d = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        cmd_o.shift = 1'b1;
        cmd_o.src   = SRC_MARK;
        mark_d      = 1'b1;
        state_d     = (status_i.fill == FillLast) ? ST_LOAD : ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (status_i.fill == LengthPos) begin
          state_d = ST_PAD_LEN;
        end else begin
          cmd_o.shift = 1'b1;
          cmd_o.src   = SRC_ZERO;
          if (status_i.fill == FillLast) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_PAD_LEN: begin
        cmd_o.shift = 1'b1;
        cmd_o.src   = SRC_LEN;
        if (status_i.fill == FillLast) begin
          len_d   = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (status_i.round_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        if (!end_q) begin
          state_d = ST_IDLE;
        end else if (len_q) begin
          state_d = ST_OUT;
        end else if (mark_q) begin
          state_d = ST_PAD_ZERO;
        end else begin
          state_d = ST_PAD_MARK;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_adv = 1'b1;
          if (status_i.idx_last) begin
            cmd_o.clear = 1'b1;
            end_d       = 1'b0;
            mark_d      = 1'b0;
            len_d       = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/sha256_byte_stream_hasher.sv @@
// sha-256 over a byte stream: one beat per cycle while a block fills
// a full block goes through load, 64 rounds and add with input held off
// end of message: padding (0x80 mark, zero fill, 64-bit bit count) plus one or two blocks,
// then eight digest beats at one per cycle while out ready is high
// async active-low reset loads the initial hash and clears fill and bit count
`include "assert_macros.svh"

module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);

  sha_cmd_t    cmd;
  sha_status_t status;

  sha_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .byte_present_i   (in_i.byte_present),
    .end_of_message_i (in_i.end_of_message),
    .out_ready_i      (out_o.ready),
    .status_i         (status),
    .in_ready_o       (in_i.ready),
    .out_valid_o      (out_o.valid),
    .cmd_o            (cmd)
  );

  sha_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_i.data_byte),
    .status_o      (status),
    .digest_word_o (out_o.digest_word),
    .word_index_o  (out_o.word_index),
    .last_word_o   (out_o.last_word)
  );

  `ASSERT_NEVER(a_in_out_excl, clk_i, rst_ni, in_i.ready && out_o.valid)
  `ASSERT_AT(a_idx_step, clk_i, rst_ni, (out_o.valid && out_o.ready && !out_o.last_word) |=> (out_o.valid && out_o.word_index == $past(out_o.word_index) + 3'd1))
  `ASSERT_AT(a_back_to_idle, clk_i, rst_ni, (out_o.valid && out_o.ready && out_o.last_word) |=> (in_i.ready && status.fill == 6'd0))
  `ASSERT_AT(a_block_full, clk_i, rst_ni, (in_i.valid && in_i.ready && in_i.byte_present && status.fill == FillLast) |=> !in_i.ready)

endmodule
